/* hw/rtl/psps_pkg.sv */
// Shared types, codes and constants of the pressure sensor poll sequencer.
`timescale 1ns / 1ps

package psps_pkg;

	localparam logic [7:0] ADDR_PT      = 8'hEC;
	localparam logic [7:0] ADDR_RH      = 8'h80;
	localparam logic [7:0] CMD_PT_RESET = 8'h1E;
	localparam logic [7:0] CMD_RH_RESET = 8'hFE;
	localparam logic [7:0] CMD_PROM     = 8'hA0;
	localparam logic [7:0] CMD_D1       = 8'h4A;
	localparam logic [7:0] CMD_D2       = 8'h5A;
	localparam logic [7:0] CMD_ADC      = 8'h00;

	localparam logic [1:0] KIND_REQ  = 2'd0;
	localparam logic [1:0] KIND_PROM = 2'd1;
	localparam logic [1:0] KIND_PAIR = 2'd2;

	localparam logic [1:0] XK_CMD   = 2'd0;
	localparam logic [1:0] XK_READ2 = 2'd1;
	localparam logic [1:0] XK_READ3 = 2'd2;

	localparam logic [1:0] REG_IDLE_WAIT = 2'd0;
	localparam logic [1:0] REG_PRES_WAIT = 2'd1;
	localparam logic [1:0] REG_TEMP_WAIT = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  device_addr;
		logic [7:0]  command;
		logic [1:0]  xfer_kind;
		logic [2:0]  prom_index;
		logic [15:0] prom_word;
		logic [15:0] pressure_raw;
		logic [15:0] temperature_raw;
		logic        is_last;
	} result_t;

	// One queue entry: the first result of an item, and whether a calibration
	// read request follows it.
	typedef struct packed {
		logic    second;
		result_t res;
	} entry_t;

	function automatic result_t req_result(input logic [7:0] addr, input logic [7:0] cmd,
			input logic [1:0] xk);
		result_t r;
		r = '0;
		r.kind = KIND_REQ;
		r.device_addr = addr;
		r.command = cmd;
		r.xfer_kind = xk;
		r.is_last = 1'b1;
		return r;
	endfunction

endpackage

/* hw/rtl/psps_front.sv */
// Front end: configuration registers, sequencer state and classification of each input beat.
`timescale 1ns / 1ps

module psps_front #(
	parameter int PROM_WORDS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               accept,
	input  logic               action,
	input  logic [7:0]         rx_low_byte,
	input  logic [7:0]         rx_high_byte,
	output logic               entry_we,
	output psps_pkg::entry_t   entry
);
	import psps_pkg::*;

	localparam logic [2:0] PH_INIT    = 3'd0;
	localparam logic [2:0] PH_IDLE    = 3'd1;
	localparam logic [2:0] PH_D1_POLL = 3'd2;
	localparam logic [2:0] PH_D2_CONV = 3'd3;
	localparam logic [2:0] PH_D2_POLL = 3'd4;

	localparam logic [2:0] TAG_NONE     = 3'd0;
	localparam logic [2:0] TAG_PT_RESET = 3'd1;
	localparam logic [2:0] TAG_RH_RESET = 3'd2;
	localparam logic [2:0] TAG_PROM     = 3'd3;
	localparam logic [2:0] TAG_D1_START = 3'd4;
	localparam logic [2:0] TAG_D1_READ  = 3'd5;
	localparam logic [2:0] TAG_D2_START = 3'd6;
	localparam logic [2:0] TAG_D2_READ  = 3'd7;

	logic [15:0] idle_wait_q, pres_wait_q, temp_wait_q;
	logic [2:0]  phase_q, phase_d;
	logic [2:0]  tag_q, tag_d;
	logic [15:0] wait_q, wait_d;
	logic        wait_off_q, wait_off_d;
	logic [2:0]  prom_pos_q, prom_pos_d;
	logic [15:0] hold_q, hold_d;
	logic [15:0] word;
	logic [3:0]  next_pos;

	assign word = {rx_high_byte, rx_low_byte};
	assign next_pos = {1'b0, prom_pos_q} + 4'd1;

	always_comb begin
		phase_d = phase_q;
		tag_d = tag_q;
		wait_d = wait_q;
		wait_off_d = wait_off_q;
		prom_pos_d = prom_pos_q;
		hold_d = hold_q;
		entry_we = 1'b0;
		entry = '0;
		if (accept) begin
			if (!action) begin
				if (!wait_off_q) begin
					if (wait_q != 16'd0) begin
						wait_d = wait_q - 16'd1;
					end else begin
						wait_off_d = 1'b1;
						case (phase_q)
							PH_INIT: begin
								entry.res = req_result(ADDR_PT, CMD_PT_RESET, XK_CMD);
								tag_d = TAG_PT_RESET;
								entry_we = 1'b1;
							end
							PH_IDLE: begin
								entry.res = req_result(ADDR_PT, CMD_D1, XK_CMD);
								tag_d = TAG_D1_START;
								entry_we = 1'b1;
							end
							PH_D1_POLL: begin
								entry.res = req_result(ADDR_PT, CMD_ADC, XK_READ3);
								tag_d = TAG_D1_READ;
								entry_we = 1'b1;
							end
							PH_D2_CONV: begin
								entry.res = req_result(ADDR_PT, CMD_D2, XK_CMD);
								tag_d = TAG_D2_START;
								entry_we = 1'b1;
							end
							PH_D2_POLL: begin
								entry.res = req_result(ADDR_PT, CMD_ADC, XK_READ3);
								tag_d = TAG_D2_READ;
								entry_we = 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
			end else if (tag_q != TAG_NONE) begin
				tag_d = TAG_NONE;
				case (tag_q)
					TAG_PT_RESET: begin
						entry.res = req_result(ADDR_RH, CMD_RH_RESET, XK_CMD);
						tag_d = TAG_RH_RESET;
						entry_we = 1'b1;
					end
					TAG_RH_RESET: begin
						prom_pos_d = 3'd0;
						entry.res = req_result(ADDR_PT, CMD_PROM, XK_READ2);
						tag_d = TAG_PROM;
						entry_we = 1'b1;
					end
					TAG_PROM: begin
						entry_we = 1'b1;
						entry.res.kind = KIND_PROM;
						entry.res.prom_index = prom_pos_q;
						entry.res.prom_word = word;
						prom_pos_d = next_pos[2:0];
						if (next_pos >= 4'(PROM_WORDS)) begin
							entry.res.is_last = 1'b1;
							phase_d = PH_IDLE;
							wait_d = idle_wait_q;
							wait_off_d = 1'b0;
						end else begin
							entry.second = 1'b1;
							tag_d = TAG_PROM;
						end
					end
					TAG_D1_START: begin
						phase_d = PH_D1_POLL;
						wait_d = pres_wait_q;
						wait_off_d = 1'b0;
					end
					TAG_D1_READ: begin
						hold_d = word;
						phase_d = PH_D2_CONV;
						wait_d = 16'd0;
						wait_off_d = 1'b0;
					end
					TAG_D2_START: begin
						phase_d = PH_D2_POLL;
						wait_d = temp_wait_q;
						wait_off_d = 1'b0;
					end
					default: begin
						entry_we = 1'b1;
						entry.res.kind = KIND_PAIR;
						entry.res.pressure_raw = hold_q;
						entry.res.temperature_raw = word;
						entry.res.is_last = 1'b1;
						phase_d = PH_IDLE;
						wait_d = idle_wait_q;
						wait_off_d = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_wait_q <= 16'd1000;
			pres_wait_q <= 16'd20;
			temp_wait_q <= 16'd20;
			phase_q <= PH_INIT;
			tag_q <= TAG_NONE;
			wait_q <= 16'd0;
			wait_off_q <= 1'b0;
			prom_pos_q <= 3'd0;
			hold_q <= 16'd0;
		end else begin
			phase_q <= phase_d;
			tag_q <= tag_d;
			wait_q <= wait_d;
			wait_off_q <= wait_off_d;
			prom_pos_q <= prom_pos_d;
			hold_q <= hold_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IDLE_WAIT: idle_wait_q <= cfg_data;
					REG_PRES_WAIT: pres_wait_q <= cfg_data;
					REG_TEMP_WAIT: temp_wait_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* hw/rtl/psps_queue.sv */
// Short queue of classified entries between the front and back ends.
`timescale 1ns / 1ps

module psps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  psps_pkg::entry_t wr_entry,
	input  logic             rd_en,
	output psps_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);
	import psps_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: begin
				end
			endcase
		end
	end

endmodule

/* hw/rtl/psps_back.sv */
// Back end: turns queue entries into result beats held in an output register.
`timescale 1ns / 1ps

module psps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  psps_pkg::entry_t head,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output psps_pkg::result_t beat
);
	import psps_pkg::*;

	logic        out_valid_q;
	logic        second_q;
	logic [2:0]  second_idx_q;
	result_t     beat_q;
	logic        load;
	logic [7:0]  second_cmd;

	assign load = !out_valid_q || pop;
	assign q_pop = load && !second_q && !q_empty;
	assign empty = !out_valid_q;
	assign beat = beat_q;
	assign second_cmd = CMD_PROM + {4'd0, second_idx_q + 3'd1, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q <= 1'b0;
			end else begin
				out_valid_q <= !q_empty;
				second_q <= !q_empty && head.second;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				beat_q <= req_result(ADDR_PT, second_cmd, XK_READ2);
			end else if (!q_empty) begin
				beat_q <= head.res;
				second_idx_q <= head.res.prom_index;
			end
		end
	end

endmodule

/* hw/rtl/pressure_sensor_poll_sequencer_unit.sv */
// Top level of the pressure sensor poll sequencer.
//
//  Channel   Handshake             Beat contents
//  input     push / full           action, rx_low_byte, rx_high_byte
//  result    empty / pop           kind, device_addr, command, xfer_kind, prom_index,
//                                  prom_word, pressure_raw, temperature_raw, is_last
//  config    cfg_wr_en             cfg_index, cfg_data
//
// An input beat is classified in the cycle it is accepted; its first result passes through
// the queue and then the output register, and a calibration word's follow-on read request
// is loaded into the output register when that word is popped. One input beat per cycle is
// taken while the four-entry queue has room; full rises when the result side stalls, or
// when calibration words, which take two result beats each, arrive on consecutive cycles.
// Reset clears the sequencer state and the queue, and marks the output register empty.
`timescale 1ns / 1ps

module pressure_sensor_poll_sequencer_unit #(
	parameter int PROM_WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  rx_low_byte,
	input  logic [7:0]  rx_high_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  device_addr,
	output logic [7:0]  command,
	output logic [1:0]  xfer_kind,
	output logic [2:0]  prom_index,
	output logic [15:0] prom_word,
	output logic [15:0] pressure_raw,
	output logic [15:0] temperature_raw,
	output logic        is_last
);
	import psps_pkg::*;

	logic    accept;
	logic    entry_we;
	entry_t  entry;
	entry_t  head;
	logic    q_full, q_empty, q_pop;
	result_t beat;

	assign accept = push && !q_full;
	assign full = q_full;

	psps_front #(
		.PROM_WORDS(PROM_WORDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.action      (action),
		.rx_low_byte (rx_low_byte),
		.rx_high_byte(rx_high_byte),
		.entry_we    (entry_we),
		.entry       (entry)
	);

	psps_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (entry_we),
		.wr_entry(entry),
		.rd_en   (q_pop),
		.rd_entry(head),
		.full    (q_full),
		.empty   (q_empty)
	);

	psps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.beat   (beat)
	);

	assign kind = beat.kind;
	assign device_addr = beat.device_addr;
	assign command = beat.command;
	assign xfer_kind = beat.xfer_kind;
	assign prom_index = beat.prom_index;
	assign prom_word = beat.prom_word;
	assign pressure_raw = beat.pressure_raw;
	assign temperature_raw = beat.temperature_raw;
	assign is_last = beat.is_last;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(entry_we && q_full))
		else $error("queue written while full");

	a_only_prom_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != KIND_PROM) |-> is_last)
		else $error("non-calibration beat not marked last");

	a_prom_followed_by_request: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && kind == KIND_PROM && !is_last) |=>
		(!empty && kind == KIND_REQ && xfer_kind == XK_READ2 && is_last))
		else $error("calibration word not followed by its read request");
`endif

endmodule
